### rtl/ort_pkg.sv
// Shared types, codes and sizes for the outstanding request tracker.
package ort_pkg;

   // Default table size
   localparam int TABLE_ENTRIES_DEF = 16;

   // Field widths
   localparam int OPCODE_W = 2;
   localparam int ID_W     = 32;
   localparam int FIELD_W  = 16;
   localparam int STATUS_W = 3;
   localparam int FREED_W  = 5;
   localparam int AGE_W    = 16;
   localparam int TIME_W   = 32;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 3;

   // Largest freed count that fits the result field
   localparam int FREED_MAX = 31;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_ISSUE  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RETIRE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAN  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_ISSUED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RETIRED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd4;

   // Register index of max_age
   localparam logic CSR_MAX_AGE_IDX = 1'b0;
   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd60;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ort_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ort_cmd_type;

endpackage

### rtl/ort_ctrl.sv
// Controller state machine: accepts a word and sequences its execute cycle.
module ort_ctrl
   import ort_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output ort_cmd_type cmd
);

   ort_state_type state_ff;
   ort_state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance: idle to execute on an accepted word, then back to idle
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive commands
   always_comb begin
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

### rtl/ort_datapath.sv
// Datapath: request table, id and seconds counters, parallel search, result register.
module ort_datapath
   import ort_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ort_cmd_type         cmd,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [FIELD_W-1:0]  req_family,
   input  logic [FIELD_W-1:0]  req_type,
   input  logic [FIELD_W-1:0]  req_flags,
   input  logic [ID_W-1:0]     req_retire_id,
   input  logic [AGE_W-1:0]    max_age,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [FIELD_W-1:0]  rsp_out_family,
   output logic [FIELD_W-1:0]  rsp_out_type,
   output logic [FIELD_W-1:0]  rsp_out_flags,
   output logic [FREED_W-1:0]  rsp_freed_count
);

   localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int REC_W  = 3 * FIELD_W;

   // Captured word
   logic [OPCODE_W-1:0] op_ff;
   logic [FIELD_W-1:0]  family_ff;
   logic [FIELD_W-1:0]  type_ff;
   logic [FIELD_W-1:0]  flags_ff;
   logic [ID_W-1:0]     retire_id_ff;

   // Table
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;
   logic [ID_W-1:0]          slot_id_ff     [TABLE_ENTRIES];
   logic [REC_W-1:0]         slot_fields_ff [TABLE_ENTRIES];
   logic [TIME_W-1:0]        slot_time_ff   [TABLE_ENTRIES];

   // Counters
   logic [ID_W-1:0]   next_id_ff;
   logic [ID_W-1:0]   next_id_in;
   logic [TIME_W-1:0] seconds_ff;
   logic [TIME_W-1:0] seconds_in;

   // Result register
   logic                strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [ID_W-1:0]     id_ff;
   logic [ID_W-1:0]     id_in;
   logic [REC_W-1:0]    rec_ff;
   logic [REC_W-1:0]    rec_in;
   logic [FREED_W-1:0]  freed_ff;
   logic [FREED_W-1:0]  freed_in;

   // Search results
   logic [TABLE_ENTRIES-1:0] free_vec;
   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [TABLE_ENTRIES-1:0] aged_vec;
   logic                     free_found;
   logic [SLOT_W-1:0]        free_idx;
   logic                     hit_found;
   logic [SLOT_W-1:0]        hit_idx;
   logic [CNT_W-1:0]         aged_cnt;
   logic [31:0]              aged_cnt32;
   logic                     write_slot;

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_opcode;
         family_ff    <= req_family;
         type_ff      <= req_type;
         flags_ff     <= req_flags;
         retire_id_ff <= req_retire_id;
      end
   end

   // Compare every entry in parallel
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         free_vec[i] = ~valid_ff[i];
         hit_vec[i]  = valid_ff[i] && (slot_id_ff[i] == retire_id_ff);
         aged_vec[i] = valid_ff[i] &&
                       ((seconds_ff - slot_time_ff[i]) > {{(TIME_W-AGE_W){1'b0}}, max_age});
      end
   end

   // Pick the lowest free and lowest matching slot, count aged entries
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      aged_cnt   = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (hit_vec[i]) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
         end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         aged_cnt = aged_cnt + CNT_W'(aged_vec[i]);
      end
   end

   assign aged_cnt32 = 32'(aged_cnt);

   // Work out the table update and the result
   always_comb begin
      valid_in   = valid_ff;
      next_id_in = next_id_ff;
      seconds_in = seconds_ff;
      status_in  = STAT_DONE;
      id_in      = '0;
      rec_in     = '0;
      freed_in   = '0;
      write_slot = 1'b0;
      case (op_ff)
         OP_ISSUE: begin
            next_id_in = next_id_ff + 1'b1;
            if (free_found) begin
               write_slot          = 1'b1;
               valid_in[free_idx]  = 1'b1;
               status_in           = STAT_ISSUED;
               id_in               = next_id_ff;
            end else begin
               status_in = STAT_FULL;
            end
         end
         OP_RETIRE: begin
            if (hit_found) begin
               valid_in[hit_idx] = 1'b0;
               status_in         = STAT_RETIRED;
               id_in             = retire_id_ff;
               rec_in            = slot_fields_ff[hit_idx];
            end else begin
               status_in = STAT_MISS;
            end
         end
         OP_TICK: begin
            seconds_in = seconds_ff + 1'b1;
         end
         OP_CLEAN: begin
            valid_in = valid_ff & ~aged_vec;
            freed_in = (aged_cnt32 > 32'(FREED_MAX)) ? FREED_W'(FREED_MAX)
                                                     : aged_cnt32[FREED_W-1:0];
         end
         default: begin
            status_in = STAT_DONE;
         end
      endcase
   end

   // Update control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         next_id_ff <= ID_W'(1);
         seconds_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff <= cmd.execute;
         if (cmd.execute) begin
            valid_ff   <= valid_in;
            next_id_ff <= next_id_in;
            seconds_ff <= seconds_in;
         end
      end
   end

   // Write the issued entry
   always_ff @(posedge clock) begin
      if (cmd.execute && write_slot) begin
         slot_id_ff[free_idx]     <= next_id_ff;
         slot_fields_ff[free_idx] <= {family_ff, type_ff, flags_ff};
         slot_time_ff[free_idx]   <= seconds_ff;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         rec_ff    <= rec_in;
         freed_ff  <= freed_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_id      = id_ff;
   assign rsp_out_family  = rec_ff[3*FIELD_W-1:2*FIELD_W];
   assign rsp_out_type    = rec_ff[2*FIELD_W-1:FIELD_W];
   assign rsp_out_flags   = rec_ff[FIELD_W-1:0];
   assign rsp_freed_count = freed_ff;

endmodule

### rtl/outstanding_request_tracker_top.sv
// Top level: command port, control register port, controller and datapath.
//
// Each word is accepted at the edge where start is high and busy is low, the whole table
// is searched by parallel compare in the execute cycle that follows (busy high), and the
// result is shown for one cycle with rsp_strobe in the next cycle, during which a new word
// may already be accepted. No new word is accepted during the execute cycle, one pass of
// the parallel slot compare. The receiver cannot stall: a result not taken in its strobe
// cycle is lost. The table needs no clearing after reset. max_age may be written at any
// time the block is idle and takes effect on the next clean.
module outstanding_request_tracker_top
   import ort_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [FIELD_W-1:0]  req_family,
   input  logic [FIELD_W-1:0]  req_type,
   input  logic [FIELD_W-1:0]  req_flags,
   input  logic [ID_W-1:0]     req_retire_id,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [FIELD_W-1:0]  rsp_out_family,
   output logic [FIELD_W-1:0]  rsp_out_type,
   output logic [FIELD_W-1:0]  rsp_out_flags,
   output logic [FREED_W-1:0]  rsp_freed_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   ort_cmd_type      cmd;
   logic [AGE_W-1:0] max_age_ff;
   logic             csr_hit;

   // Decode the register index
   assign csr_hit = (paddr[ADDR_W-1] == CSR_MAX_AGE_IDX);
   assign pready  = 1'b1;

   // Hold max_age
   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_AGE_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         max_age_ff <= pwdata[AGE_W-1:0];
      end
   end

   // Read back
   assign prdata = csr_hit ? {{(CSR_W-AGE_W){1'b0}}, max_age_ff} : '0;

   ort_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ort_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_family      (req_family),
      .req_type        (req_type),
      .req_flags       (req_flags),
      .req_retire_id   (req_retire_id),
      .max_age         (max_age_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_family  (rsp_out_family),
      .rsp_out_type    (rsp_out_type),
      .rsp_out_flags   (rsp_out_flags),
      .rsp_freed_count (rsp_freed_count)
   );

endmodule

### rtl/ort_checker.sv
// Port-level checker for the tracker and its bind to the top level.
module ort_checker
   import ort_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [FIELD_W-1:0]  rsp_out_family,
   input logic [FIELD_W-1:0]  rsp_out_type,
   input logic [FIELD_W-1:0]  rsp_out_flags,
   input logic [FREED_W-1:0]  rsp_freed_count
);

   // An accepted word is worked on in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // Busy lasts one cycle and is followed by exactly one result
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe))
      else $error("execute cycle not followed by a result");

   // No result without a preceding execute cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a word");

   // Entry fields only come back from a retire
   a_fields_retire: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_RETIRED)) |->
         (rsp_out_family == '0 && rsp_out_type == '0 && rsp_out_flags == '0))
      else $error("entry fields on a non-retire result");

   // Freed count only comes back from a done result
   a_freed_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_DONE)) |-> (rsp_freed_count == '0))
      else $error("freed count on a non-clean result");

endmodule

bind outstanding_request_tracker_top ort_checker u_ort_checker (.*);

### bench/tb_outstanding_request_tracker_top.sv
// Self-checking testbench for the outstanding request tracker: issue, retire, tick, clean.
`timescale 1ns / 100ps

module tb_outstanding_request_tracker_top;
   import ort_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int RESET_CYCLES  = 12;
   localparam int STALL_LIMIT   = 500;
   localparam int PRINT_LIMIT   = 40;
   localparam int PHASE_WORDS   = 200;
   localparam int AGE_TICKS     = 20;

   // Byte addresses of the control registers
   localparam logic [ADDR_W-1:0] MAX_AGE_ADDR = ADDR_W'(4 * CSR_MAX_AGE_IDX);
   localparam logic [ADDR_W-1:0] SPARE_ADDR   = ADDR_W'(4);

   // One result word as the block reports it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     id;
      logic [FIELD_W-1:0]  family;
      logic [FIELD_W-1:0]  subtype;
      logic [FIELD_W-1:0]  flags;
      logic [FREED_W-1:0]  freed;
   } tracker_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode;
   logic [FIELD_W-1:0]  req_family;
   logic [FIELD_W-1:0]  req_type;
   logic [FIELD_W-1:0]  req_flags;
   logic [ID_W-1:0]     req_retire_id;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_out_id;
   logic [FIELD_W-1:0]  rsp_out_family;
   logic [FIELD_W-1:0]  rsp_out_type;
   logic [FIELD_W-1:0]  rsp_out_flags;
   logic [FREED_W-1:0]  rsp_freed_count;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [CSR_W-1:0]    pwdata;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // Shadow copy of the tracker table and counters
   logic                slot_live  [TABLE_ENTRIES];
   logic [ID_W-1:0]     slot_req_id[TABLE_ENTRIES];
   logic [FIELD_W-1:0]  slot_family[TABLE_ENTRIES];
   logic [FIELD_W-1:0]  slot_sub   [TABLE_ENTRIES];
   logic [FIELD_W-1:0]  slot_flags [TABLE_ENTRIES];
   logic [TIME_W-1:0]   slot_stamp [TABLE_ENTRIES];
   logic [ID_W-1:0]     model_next_id;
   logic [TIME_W-1:0]   model_seconds;
   logic [AGE_W-1:0]    model_max_age;

   tracker_result_type pending_results[$];
   int  error_count;
   int  idle_cycles;
   bit  gaps_on;

   outstanding_request_tracker_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_family      (req_family),
      .req_type        (req_type),
      .req_flags       (req_flags),
      .req_retire_id   (req_retire_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_family  (rsp_out_family),
      .rsp_out_type    (rsp_out_type),
      .rsp_out_flags   (rsp_out_flags),
      .rsp_freed_count (rsp_freed_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Apply one word to the shadow table and return the result it must produce
   function automatic tracker_result_type predict_tracker(input logic [OPCODE_W-1:0] op,
                                                          input logic [FIELD_W-1:0] fam,
                                                          input logic [FIELD_W-1:0] sub,
                                                          input logic [FIELD_W-1:0] flg,
                                                          input logic [ID_W-1:0] rid);
      tracker_result_type r;
      logic            found;
      logic [TIME_W-1:0] age;
      r = '0;
      found = 1'b0;
      case (op)
         OP_ISSUE: begin
            r.status = STAT_FULL;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!found && !slot_live[i]) begin
                  found = 1'b1;
                  slot_live[i]   = 1'b1;
                  slot_req_id[i] = model_next_id;
                  slot_family[i] = fam;
                  slot_sub[i]    = sub;
                  slot_flags[i]  = flg;
                  slot_stamp[i]  = model_seconds;
                  r.status = STAT_ISSUED;
                  r.id     = model_next_id;
               end
            end
            // the id counter advances even on a full table
            model_next_id = model_next_id + 1'b1;
         end
         OP_RETIRE: begin
            r.status = STAT_MISS;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!found && slot_live[i] && slot_req_id[i] == rid) begin
                  found = 1'b1;
                  slot_live[i] = 1'b0;
                  r.status  = STAT_RETIRED;
                  r.id      = rid;
                  r.family  = slot_family[i];
                  r.subtype = slot_sub[i];
                  r.flags   = slot_flags[i];
               end
            end
         end
         OP_TICK: begin
            model_seconds = model_seconds + 1'b1;
            r.status = STAT_DONE;
         end
         default: begin
            r.status = STAT_DONE;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               age = model_seconds - slot_stamp[i];
               if (slot_live[i] && age > TIME_W'(model_max_age)) begin
                  slot_live[i] = 1'b0;
                  if (r.freed < FREED_W'(FREED_MAX))
                     r.freed = r.freed + 1'b1;
               end
            end
         end
      endcase
      return r;
   endfunction

   // Random idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one word, hold it until accepted, then record its expected result
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] fam,
                            input logic [FIELD_W-1:0] sub, input logic [FIELD_W-1:0] flg,
                            input logic [ID_W-1:0] rid);
      int gap;
      req_opcode    <= op;
      req_family    <= fam;
      req_type      <= sub;
      req_flags     <= flg;
      req_retire_id <= rid;
      start         <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      pending_results.push_back(predict_tracker(op, fam, sub, flg, rid));
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and wait until every expected result has arrived
   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() > 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Register write: setup phase, then access phase
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == MAX_AGE_ADDR)
         model_max_age = data[AGE_W-1:0];
      @(posedge clock);
   endtask

   // Register read: setup phase, then access phase, data taken at the end of the access cycle
   task automatic csr_read(input logic [ADDR_W-1:0] addr, output logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_mismatch_if(input logic [AGE_W-1:0] got, input logic [AGE_W-1:0] want);
      if (got !== want)
         report_mismatch("max_age readback", 32'(got), 32'(want));
   endtask

   // Check the register holds the shadow max_age
   task automatic check_max_age();
      logic [CSR_W-1:0] rd;
      csr_read(MAX_AGE_ADDR, rd);
      report_mismatch_if(rd[AGE_W-1:0], model_max_age);
   endtask

   // Compare each result word against the oldest expectation
   always @(posedge clock) begin
      tracker_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_status), 32'hffff_ffff);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_out_id !== want.id)
               report_mismatch("out_id", rsp_out_id, want.id);
            if (rsp_out_family !== want.family)
               report_mismatch("out_family", 32'(rsp_out_family), 32'(want.family));
            if (rsp_out_type !== want.subtype)
               report_mismatch("out_type", 32'(rsp_out_type), 32'(want.subtype));
            if (rsp_out_flags !== want.flags)
               report_mismatch("out_flags", 32'(rsp_out_flags), 32'(want.flags));
            if (rsp_freed_count !== want.freed)
               report_mismatch("freed_count", 32'(rsp_freed_count), 32'(want.freed));
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Empty table: tick, clean and retires that cannot hit
   task automatic test_empty_table();
      check_max_age();
      send_word(OP_CLEAN, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
      send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send_word(OP_RETIRE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send_word(OP_RETIRE, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
      drain_results();
   endtask

   // Fill every slot with extreme field values, overflow once, retire hits and a miss
   task automatic test_fill_and_full();
      logic [FIELD_W-1:0] pattern[4];
      logic [ID_W-1:0]    first_id;
      logic [ID_W-1:0]    lost_id;
      pattern = '{16'h0000, 16'hffff, 16'haaaa, 16'h5555};
      first_id = model_next_id;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         send_word(OP_ISSUE, pattern[i % 4], pattern[(i + 1) % 4], pattern[(i + 2) % 4],
                   32'(i));
      lost_id = model_next_id;
      send_word(OP_ISSUE, 16'h1234, 16'h5678, 16'h9abc, 32'h0);
      send_word(OP_RETIRE, 16'h0, 16'h0, 16'h0, first_id + ID_W'(TABLE_ENTRIES - 1));
      send_word(OP_RETIRE, 16'h0, 16'h0, 16'h0, first_id);
      send_word(OP_RETIRE, 16'h0, 16'h0, 16'h0, lost_id);
      drain_results();
   endtask

   // max_age at zero frees anything a tick old; the spare register address is ignored
   task automatic test_ageing();
      csr_write(MAX_AGE_ADDR, {16'hdead, 16'h0000});
      csr_write(SPARE_ADDR, 32'hffff_ffff);
      check_max_age();
      send_word(OP_CLEAN, 16'h0, 16'h0, 16'h0, 32'h0);
      send_word(OP_TICK, 16'h0, 16'h0, 16'h0, 32'h0);
      send_word(OP_CLEAN, 16'h0, 16'h0, 16'h0, 32'h0);
      drain_results();
   endtask

   // Largest max_age keeps an aged entry; it goes once its age passes max_age
   task automatic test_longest_age();
      csr_write(MAX_AGE_ADDR, 32'h0000_ffff);
      check_max_age();
      gaps_on = 1'b0;
      send_word(OP_ISSUE, 16'hc3c3, 16'h3c3c, 16'h0ff0, 32'h0);
      for (int i = 0; i < AGE_TICKS; i++)
         send_word(OP_TICK, 16'h0, 16'h0, 16'h0, 32'h0);
      send_word(OP_CLEAN, 16'h0, 16'h0, 16'h0, 32'h0);
      drain_results();
      // age equal to max_age survives, one second more is freed
      csr_write(MAX_AGE_ADDR, 32'(AGE_TICKS));
      check_max_age();
      send_word(OP_CLEAN, 16'h0, 16'h0, 16'h0, 32'h0);
      send_word(OP_TICK, 16'h0, 16'h0, 16'h0, 32'h0);
      send_word(OP_CLEAN, 16'h0, 16'h0, 16'h0, 32'h0);
      gaps_on = 1'b1;
      drain_results();
   endtask

   // Mostly issue/retire traffic on live ids, with ticks, cleans and stray ids
   task automatic run_random_phase(input int count);
      int                  r;
      int                  live;
      int                  pick;
      logic [OPCODE_W-1:0] op;
      logic [ID_W-1:0]     rid;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         rid = $urandom;
         if (r < 38)
            op = OP_ISSUE;
         else if (r < 76)
            op = OP_RETIRE;
         else if (r < 90)
            op = OP_TICK;
         else
            op = OP_CLEAN;
         if (op == OP_RETIRE) begin
            live = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (slot_live[i])
                  live++;
            r = $urandom_range(0, 9);
            if (r < 8 && live > 0) begin
               // target one of the outstanding ids
               pick = $urandom_range(0, live - 1);
               for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (slot_live[i]) begin
                     if (pick == 0)
                        rid = slot_req_id[i];
                     pick--;
                  end
               end
            end else if (r == 9) begin
               // recent id: likely already retired, aged out or never stored
               rid = model_next_id - ID_W'($urandom_range(1, 24));
            end
         end
         send_word(op, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), rid);
      end
      drain_results();
   endtask

   // Random traffic under several max_age settings
   task automatic test_random_traffic();
      logic [AGE_W-1:0] ages[6];
      ages = '{16'd0, 16'd1, 16'd3, 16'd8, 16'hffff, AGE_W'($urandom_range(0, 20))};
      for (int p = 0; p < 6; p++) begin
         csr_write(MAX_AGE_ADDR, {16'($urandom), ages[p]});
         check_max_age();
         // one phase with no idle cycles at all
         gaps_on = (p != 2);
         run_random_phase(PHASE_WORDS);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = OP_TICK;
      req_family    = '0;
      req_type      = '0;
      req_flags     = '0;
      req_retire_id = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      error_count   = 0;
      gaps_on       = 1'b1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         slot_live[i]   = 1'b0;
         slot_req_id[i] = '0;
         slot_family[i] = '0;
         slot_sub[i]    = '0;
         slot_flags[i]  = '0;
         slot_stamp[i]  = '0;
      end
      model_next_id = 32'd1;
      model_seconds = '0;
      model_max_age = MAX_AGE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_and_full();
      test_ageing();
      test_longest_age();
      test_random_traffic();

      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
